// ===== sv/swt_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swt_pkg
// Shared types, codes and helpers of the sorted word table.
// ----------------------------------------------------------------------------
package swt_pkg;

  localparam int TABLE_DEPTH_DEF    = 256;
  localparam int MAX_WORD_CHARS_DEF = 40;
  localparam int QUEUE_DEPTH        = 4;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_UNIQUE = 2'd1;
  localparam logic [1:0] OP_SEARCH = 2'd2;
  localparam logic [1:0] OP_REMOVE = 2'd3;

  localparam logic [2:0] ST_INSERTED  = 3'd0;
  localparam logic [2:0] ST_DUPLICATE = 3'd1;
  localparam logic [2:0] ST_FOUND     = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_REMOVED   = 3'd4;
  localparam logic [2:0] ST_FULL      = 3'd5;
  localparam logic [2:0] ST_TOO_LONG  = 3'd6;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] key_char;
    logic       key_last;
  } item_t;

  // ASCII case fold: A-Z map onto a-z
  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'd65 && c <= 8'd90) begin
      r = c + 8'd32;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== sv/sorted_word_table_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_word_table_unit
// Sorted word table: words arrive a character per request; the last
// character runs an insert, unique insert, search or remove.
// ----------------------------------------------------------------------------
//  channel   handshake      payload
//  request   push / full    opcode, key_char, key_last
//  result    pop / empty    status, position, word_total
//
// A character request that is not last is only stored in the key buffer.
// A compare against one entry reads its length byte, then compares the
// folded chars one by one; search is one probe chain plus possibly a linear scan.
// Insert and remove move (entries after the slot) * (MAX_WORD_CHARS+1)
// bytes through the single table RAM port pair, one byte a cycle.
// Reset (rst, synchronous) empties the table; no RAM clearing pass.
// The request queue accepts until full while the engine works or a result
// waits; the engine stalls only when a new result meets an untaken one.
// ----------------------------------------------------------------------------
module sorted_word_table_unit #(
  parameter int TABLE_DEPTH    = swt_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_WORD_CHARS = swt_pkg::MAX_WORD_CHARS_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  output logic            full,
  input  wire logic [1:0] opcode,
  input  wire logic [7:0] key_char,
  input  wire logic       key_last,
  output logic            empty,
  input  wire logic       pop,
  output logic [2:0]      status,
  output logic [7:0]      position,
  output logic [8:0]      word_total
);
  import swt_pkg::*;

  item_t in_item;
  item_t q_item;
  logic  q_valid;
  logic  q_ready;

  assign in_item.opcode   = opcode;
  assign in_item.key_char = key_char;
  assign in_item.key_last = key_last;

  // front: request queue
  swt_front u_front (
    .clk(clk), .rst(rst), .push(push), .full(full), .in_item(in_item),
    .q_valid(q_valid), .q_item(q_item), .q_ready(q_ready)
  );

  // back: key gather, search, shift and result register
  swt_engine #(
    .TABLE_DEPTH(TABLE_DEPTH), .MAX_WORD_CHARS(MAX_WORD_CHARS)
  ) u_engine (
    .clk(clk), .rst(rst), .q_valid(q_valid), .q_item(q_item),
    .q_ready(q_ready), .empty(empty), .pop(pop), .status(status),
    .position(position), .word_total(word_total)
  );

endmodule
`default_nettype wire

// ===== sv/swt_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swt_ram
// Generic single write port RAM with registered read.
// ----------------------------------------------------------------------------
module swt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// ===== sv/swt_front.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swt_front
// Request intake: a short queue that decouples the port from the engine.
// ----------------------------------------------------------------------------
module swt_front (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          push,
  output logic               full,
  input  wire swt_pkg::item_t in_item,
  output logic               q_valid,
  output swt_pkg::item_t     q_item,
  input  wire logic          q_ready
);
  import swt_pkg::*;

  localparam int PW = $clog2(QUEUE_DEPTH);

  item_t         slots [QUEUE_DEPTH];
  logic [PW-1:0] wptr;
  logic [PW-1:0] rptr;
  logic [PW:0]   fill;
  logic          do_push;
  logic          do_pop;

  assign full    = (fill == (PW+1)'(QUEUE_DEPTH));
  assign q_valid = (fill != '0);
  assign q_item  = slots[rptr];
  assign do_push = push && !full;
  assign do_pop  = q_valid && q_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wptr] <= in_item;
    end
    if (rst) begin
      wptr <= '0;
      rptr <= '0;
      fill <= '0;
    end else begin
      if (do_push) wptr <= wptr + PW'(1);
      if (do_pop)  rptr <= rptr + PW'(1);
      if (do_push && !do_pop) fill <= fill + (PW+1)'(1);
      else if (!do_push && do_pop) fill <= fill - (PW+1)'(1);
    end
  end

endmodule
`default_nettype wire

// ===== sv/swt_engine.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// swt_engine
// Gathers key characters and runs the table operations: probe search,
// sorted insert and remove, with entry shifts done one byte per cycle.
// ----------------------------------------------------------------------------
module swt_engine #(
  parameter int TABLE_DEPTH    = swt_pkg::TABLE_DEPTH_DEF,
  parameter int MAX_WORD_CHARS = swt_pkg::MAX_WORD_CHARS_DEF
) (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           q_valid,
  input  wire swt_pkg::item_t q_item,
  output logic                q_ready,
  output logic                empty,
  input  wire logic           pop,
  output logic [2:0]          status,
  output logic [7:0]          position,
  output logic [8:0]          word_total
);
  import swt_pkg::*;

  localparam int STRIDE = MAX_WORD_CHARS + 1;   // length byte, then chars
  localparam int TDEPTH = TABLE_DEPTH * STRIDE;
  localparam int AW     = $clog2(TDEPTH);
  localparam int CW     = $clog2(TABLE_DEPTH + 1);
  localparam int KLW    = $clog2(MAX_WORD_CHARS + 1);
  localparam int KAW    = (MAX_WORD_CHARS > 1) ? $clog2(MAX_WORD_CHARS) : 1;

  localparam logic [4:0] S_GATHER   = 5'd0;
  localparam logic [4:0] S_DISPATCH = 5'd1;
  localparam logic [4:0] S_CB       = 5'd2;
  localparam logic [4:0] S_CLR      = 5'd3;
  localparam logic [4:0] S_CL       = 5'd4;
  localparam logic [4:0] S_CRD      = 5'd5;
  localparam logic [4:0] S_CEV      = 5'd6;
  localparam logic [4:0] S_PROBE    = 5'd7;
  localparam logic [4:0] S_SCAN     = 5'd8;
  localparam logic [4:0] S_SCANR    = 5'd9;
  localparam logic [4:0] S_INS_SCAN = 5'd10;
  localparam logic [4:0] S_INS_CHK  = 5'd11;
  localparam logic [4:0] S_ISET     = 5'd12;
  localparam logic [4:0] S_RSET     = 5'd13;
  localparam logic [4:0] S_SHIFT    = 5'd14;
  localparam logic [4:0] S_WBASE    = 5'd15;
  localparam logic [4:0] S_WLEN     = 5'd16;
  localparam logic [4:0] S_WRD      = 5'd17;
  localparam logic [4:0] S_WWR      = 5'd18;
  localparam logic [4:0] S_REM_DONE = 5'd19;
  localparam logic [4:0] S_OUT      = 5'd20;
  localparam logic [4:0] S_FOUND    = 5'd21;
  localparam logic [4:0] S_NFOUND   = 5'd22;

  localparam logic [1:0] CMP_LT = 2'd0;
  localparam logic [1:0] CMP_EQ = 2'd1;
  localparam logic [1:0] CMP_GT = 2'd2;

  logic [4:0]     state;
  logic [4:0]     ret;
  logic [1:0]     op;
  logic [KLW-1:0] klen;
  logic           kovf;
  logic [CW-1:0]  count;
  logic [CW-1:0]  first;
  logic [CW-1:0]  last;
  logic [CW-1:0]  mid;
  logic [CW-1:0]  scan;
  logic [CW-1:0]  pos;
  logic [CW-1:0]  hit;
  logic [CW-1:0]  cmp_e;
  logic [AW-1:0]  cmp_base;
  logic [KLW-1:0] ci;
  logic [KLW-1:0] lb;
  logic [1:0]     cmp_res;
  logic [AW-1:0]  rd_a;
  logic [AW-1:0]  lim;
  logic           up;
  logic           more;
  logic           pend;
  logic [AW-1:0]  pend_a;
  logic [2:0]     fst;
  logic [CW-1:0]  fpos;
  logic           res_valid;

  logic           k_we;
  logic [KAW-1:0] k_waddr;
  logic [KAW-1:0] k_raddr;
  logic [7:0]     k_rdata;
  logic           t_we;
  logic [AW-1:0]  t_waddr;
  logic [7:0]     t_wdata;
  logic [AW-1:0]  t_raddr;
  logic [7:0]     t_rdata;

  logic [7:0]     fa;
  logic [7:0]     fb;
  logic [CW:0]    mid_sum;
  logic [CW-1:0]  mid1;
  logic [AW:0]    cnt_end;
  logic [CW+8:0]  pos_ext;
  logic [CW+8:0]  tot_ext;

  swt_ram #(.WIDTH(8), .DEPTH(MAX_WORD_CHARS)) u_key (
    .clk(clk), .we(k_we), .waddr(k_waddr), .wdata(q_item.key_char),
    .raddr(k_raddr), .rdata(k_rdata)
  );

  swt_ram #(.WIDTH(8), .DEPTH(TDEPTH)) u_table (
    .clk(clk), .we(t_we), .waddr(t_waddr), .wdata(t_wdata),
    .raddr(t_raddr), .rdata(t_rdata)
  );

  assign q_ready  = (state == S_GATHER);
  assign k_we     = q_ready && q_valid && (klen < KLW'(MAX_WORD_CHARS));
  assign k_waddr  = klen[KAW-1:0];
  assign k_raddr  = ci[KAW-1:0];
  assign fa       = fold_case(k_rdata);
  assign fb       = fold_case(t_rdata);
  assign mid1     = mid + CW'(1);
  assign mid_sum  = {1'b0, mid1} + {1'b0, last};
  assign cnt_end  = (AW+1)'(count) * (AW+1)'(STRIDE) - (AW+1)'(1);
  assign empty    = !res_valid;

  always_comb begin
    t_we    = 1'b0;
    t_waddr = pend_a;
    t_wdata = t_rdata;
    t_raddr = rd_a;
    case (state)
      S_CLR: begin
        t_raddr = cmp_base;
      end
      S_CRD: begin
        t_raddr = cmp_base + AW'(ci) + AW'(1);
      end
      S_SHIFT: begin
        t_we = pend;
      end
      S_WLEN: begin
        t_we    = 1'b1;
        t_waddr = cmp_base;
        t_wdata = 8'(klen);
      end
      S_WWR: begin
        t_we    = 1'b1;
        t_waddr = cmp_base + AW'(ci) + AW'(1);
        t_wdata = k_rdata;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_GATHER;
      klen      <= '0;
      kovf      <= 1'b0;
      count     <= '0;
      res_valid <= 1'b0;
      pend      <= 1'b0;
      more      <= 1'b0;
    end else begin
      if (pop && res_valid) res_valid <= 1'b0;
      case (state)
        S_GATHER: begin
          if (q_valid) begin
            if (klen < KLW'(MAX_WORD_CHARS)) klen <= klen + KLW'(1);
            else kovf <= 1'b1;
            if (q_item.key_last) begin
              op    <= q_item.opcode;
              state <= S_DISPATCH;
            end
          end
        end
        S_DISPATCH: begin
          fpos <= '0;
          if (kovf) begin
            fst   <= ST_TOO_LONG;
            state <= S_OUT;
          end else if (op == OP_LOAD) begin
            if (count >= CW'(TABLE_DEPTH)) begin
              fst   <= ST_FULL;
              state <= S_OUT;
            end else begin
              pos   <= count;
              state <= S_INS_SCAN;
            end
          end else if (count == '0) begin
            state <= S_NFOUND;
          end else begin
            first <= '0;
            last  <= count - CW'(1);
            mid   <= (count - CW'(1)) >> 1;
            cmp_e <= (count - CW'(1)) >> 1;
            ret   <= S_PROBE;
            state <= S_CB;
          end
        end
        // ---- compare key against entry cmp_e ----
        S_CB: begin
          cmp_base <= AW'(cmp_e) * AW'(STRIDE);
          state    <= S_CLR;
        end
        S_CLR: begin
          state <= S_CL;
        end
        S_CL: begin
          lb    <= t_rdata[KLW-1:0];
          ci    <= '0;
          state <= S_CRD;
        end
        S_CRD: begin
          if (ci == klen || ci == lb) begin
            if (klen < lb) cmp_res <= CMP_LT;
            else if (klen > lb) cmp_res <= CMP_GT;
            else cmp_res <= CMP_EQ;
            state <= ret;
          end else begin
            state <= S_CEV;
          end
        end
        S_CEV: begin
          if (fa != fb) begin
            cmp_res <= (fa < fb) ? CMP_LT : CMP_GT;
            state   <= ret;
          end else begin
            ci    <= ci + KLW'(1);
            state <= S_CRD;
          end
        end
        // ---- probe search ----
        S_PROBE: begin
          case (cmp_res)
            CMP_EQ: begin
              hit   <= mid;
              state <= S_FOUND;
            end
            CMP_LT: begin
              scan  <= first;
              state <= S_SCAN;
            end
            default: begin
              first <= mid1;
              if (mid1 <= last) begin
                mid   <= mid_sum[CW:1];
                cmp_e <= mid_sum[CW:1];
                ret   <= S_PROBE;
                state <= S_CB;
              end else begin
                state <= S_NFOUND;
              end
            end
          endcase
        end
        S_SCAN: begin
          if (scan < mid) begin
            cmp_e <= scan;
            ret   <= S_SCANR;
            state <= S_CB;
          end else begin
            state <= S_NFOUND;
          end
        end
        S_SCANR: begin
          if (cmp_res == CMP_EQ) begin
            hit   <= scan;
            state <= S_FOUND;
          end else begin
            scan  <= scan + CW'(1);
            state <= S_SCAN;
          end
        end
        S_FOUND: begin
          fpos <= hit;
          case (op)
            OP_UNIQUE: begin
              fst   <= ST_DUPLICATE;
              state <= S_OUT;
            end
            OP_SEARCH: begin
              fst   <= ST_FOUND;
              state <= S_OUT;
            end
            default: begin
              pos   <= hit;
              state <= S_RSET;
            end
          endcase
        end
        S_NFOUND: begin
          fpos <= '0;
          if (op == OP_UNIQUE) begin
            if (count >= CW'(TABLE_DEPTH)) begin
              fst   <= ST_FULL;
              state <= S_OUT;
            end else begin
              pos   <= count;
              state <= S_INS_SCAN;
            end
          end else begin
            fst   <= ST_NOT_FOUND;
            state <= S_OUT;
          end
        end
        // ---- insert: walk down past greater entries ----
        S_INS_SCAN: begin
          if (pos != '0) begin
            cmp_e <= pos - CW'(1);
            ret   <= S_INS_CHK;
            state <= S_CB;
          end else begin
            state <= S_ISET;
          end
        end
        S_INS_CHK: begin
          if (cmp_res == CMP_LT) begin
            pos   <= pos - CW'(1);
            state <= S_INS_SCAN;
          end else begin
            state <= S_ISET;
          end
        end
        S_ISET: begin
          up   <= 1'b1;
          rd_a <= cnt_end[AW-1:0];
          lim  <= AW'(pos) * AW'(STRIDE);
          more <= 1'b1;
          state <= (pos == count) ? S_WBASE : S_SHIFT;
        end
        S_RSET: begin
          up   <= 1'b0;
          rd_a <= AW'(pos + CW'(1)) * AW'(STRIDE);
          lim  <= cnt_end[AW-1:0];
          more <= 1'b1;
          state <= (pos + CW'(1) == count) ? S_REM_DONE : S_SHIFT;
        end
        // ---- byte-wise block move, read and write overlapped ----
        S_SHIFT: begin
          if (more) begin
            pend   <= 1'b1;
            pend_a <= up ? (rd_a + AW'(STRIDE)) : (rd_a - AW'(STRIDE));
            if (rd_a == lim) more <= 1'b0;
            else rd_a <= up ? (rd_a - AW'(1)) : (rd_a + AW'(1));
          end else begin
            pend <= 1'b0;
            if (!pend) state <= up ? S_WBASE : S_REM_DONE;
          end
        end
        // ---- write the key into its slot ----
        S_WBASE: begin
          cmp_base <= AW'(pos) * AW'(STRIDE);
          state    <= S_WLEN;
        end
        S_WLEN: begin
          ci    <= '0;
          state <= S_WRD;
        end
        S_WRD: begin
          if (ci == klen) begin
            count <= count + CW'(1);
            fst   <= ST_INSERTED;
            fpos  <= pos;
            state <= S_OUT;
          end else begin
            state <= S_WWR;
          end
        end
        S_WWR: begin
          ci    <= ci + KLW'(1);
          state <= S_WRD;
        end
        S_REM_DONE: begin
          count <= count - CW'(1);
          fst   <= ST_REMOVED;
          fpos  <= pos;
          state <= S_OUT;
        end
        S_OUT: begin
          if (!res_valid || pop) begin
            res_valid <= 1'b1;
            klen      <= '0;
            kovf      <= 1'b0;
            state     <= S_GATHER;
          end
        end
        default: begin
          state <= S_GATHER;
        end
      endcase
    end
  end

  assign pos_ext = (CW+9)'(fpos);
  assign tot_ext = (CW+9)'(count);

  always_ff @(posedge clk) begin
    if (state == S_OUT && (!res_valid || pop)) begin
      status     <= fst;
      position   <= pos_ext[7:0];
      word_total <= tot_ext[8:0];
    end
  end

endmodule
`default_nettype wire
